// ===== hdl/ows_pkg.sv =====
// Shared types, codes and defaults for the 1-Wire Search ROM engine.
`timescale 1ns / 1ps

package ows_pkg;

   // Default ROM code length in bits.
   localparam int ROM_BITS_DEFAULT = 64;

   // Width of the rom_code result field.
   localparam int ROM_CODE_W = 64;

   // Input command codes.
   localparam logic [1:0] CMD_NEW  = 2'd0;
   localparam logic [1:0] CMD_CONT = 2'd1;
   localparam logic [1:0] CMD_PAIR = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_STARTED = 3'd0;
   localparam logic [2:0] STATUS_BIT     = 3'd1;
   localparam logic [2:0] STATUS_FOUND   = 3'd2;
   localparam logic [2:0] STATUS_FAIL    = 3'd3;
   localparam logic [2:0] STATUS_IGNORED = 3'd4;

   // Operation kinds after classification.
   localparam logic [1:0] OP_NEW  = 2'd0;
   localparam logic [1:0] OP_CONT = 2'd1;
   localparam logic [1:0] OP_PAIR = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   // One classified transaction as it travels from front to back.
   typedef struct packed {
      logic [1:0] kind;
      logic       presence;
      logic       id_bit;
      logic       both_zero;   // both slots read 0: two devices disagree here
      logic       fail;        // both slots read 1: nobody answered
   } op_type;

endpackage

// ===== hdl/ows_front.sv =====
// Front end: accepts request transactions and classifies them into operations.
`timescale 1ns / 1ps

module ows_front (
   input  logic            req_valid,
   input  logic [1:0]      req_command,
   input  logic            req_presence_ok,
   input  logic            req_id_bit,
   input  logic            req_complement_bit,
   input  logic            queue_full,
   output logic            req_stall,
   output logic            push,
   output ows_pkg::op_type push_op
);

   // Take a transaction whenever the queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Decode the command and pre-compute the bit-pair cases.
   always_comb begin
      push_op           = '0;
      push_op.presence  = req_presence_ok;
      push_op.id_bit    = req_id_bit;
      push_op.both_zero = !req_id_bit && !req_complement_bit;
      push_op.fail      = req_id_bit && req_complement_bit;
      unique case (req_command)
         ows_pkg::CMD_NEW:  push_op.kind = ows_pkg::OP_NEW;
         ows_pkg::CMD_CONT: push_op.kind = ows_pkg::OP_CONT;
         ows_pkg::CMD_PAIR: push_op.kind = ows_pkg::OP_PAIR;
         default:           push_op.kind = ows_pkg::OP_NOP;
      endcase
   end

endmodule

// ===== hdl/ows_queue.sv =====
// Two-entry queue of classified operations between front and back.
`timescale 1ns / 1ps

module ows_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ows_pkg::op_type push_op,
   input  logic            pop,
   output ows_pkg::op_type head_op,
   output logic            empty,
   output logic            full
);

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   ows_pkg::op_type    entry_ff [Depth];
   ows_pkg::op_type    entry_in [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CntW'(Depth));
   assign head_op = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_op;
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/ows_back.sv =====
// Back end: search state, direction choice and the registered response.
`timescale 1ns / 1ps

module ows_back #(
   parameter int ROM_BITS = ows_pkg::ROM_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           op_valid,
   input  ows_pkg::op_type                op,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic                           rsp_direction_bit,
   output logic [ows_pkg::ROM_CODE_W-1:0] rsp_rom_code,
   output logic                           rsp_more_devices
);

   localparam int PosW = $clog2(ROM_BITS + 1);
   localparam int IdxW = $clog2(ROM_BITS);

   logic [ROM_BITS-1:0] rom_ff, rom_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [PosW-1:0]     last_disc_ff, last_disc_in;
   logic [PosW-1:0]     pass_disc_ff, pass_disc_in;
   logic                done_ff, done_in;
   logic                active_ff, active_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          status_ff, status_in;
   logic                dir_ff, dir_in;
   logic [ows_pkg::ROM_CODE_W-1:0] code_ff, code_in;
   logic                more_ff, more_in;

   logic [IdxW-1:0]     idx;
   logic [PosW-1:0]     pos_minus1;
   logic                dir;
   logic                done_eff;

   // Execute the head operation when the response register is free or draining.
   assign pop = op_valid && (!rsp_valid_ff || !rsp_stall);

   assign pos_minus1 = pos_ff - 1'b1;
   assign idx        = pos_minus1[IdxW-1:0];

   always_comb begin
      rom_in       = rom_ff;
      pos_in       = pos_ff;
      last_disc_in = last_disc_ff;
      pass_disc_in = pass_disc_ff;
      done_in      = done_ff;
      active_in    = active_ff;
      status_in    = status_ff;
      dir_in       = dir_ff;
      code_in      = code_ff;
      more_in      = more_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dir          = 1'b0;
      done_eff     = done_ff;

      if (pop) begin
         rsp_valid_in = 1'b1;
         status_in    = ows_pkg::STATUS_IGNORED;
         dir_in       = 1'b0;
         code_in      = '0;
         more_in      = 1'b0;
         unique case (op.kind) inside
            ows_pkg::OP_NEW, ows_pkg::OP_CONT: begin
               // A new search forgets the previous passes first.
               if (op.kind == ows_pkg::OP_NEW) begin
                  last_disc_in = '0;
                  done_in      = 1'b0;
                  done_eff     = 1'b0;
               end
               if (!op.presence || done_eff) begin
                  last_disc_in = '0;
                  active_in    = 1'b0;
                  status_in    = ows_pkg::STATUS_FAIL;
               end else begin
                  active_in    = 1'b1;
                  pos_in       = PosW'(1);
                  pass_disc_in = '0;
                  status_in    = ows_pkg::STATUS_STARTED;
               end
            end
            ows_pkg::OP_PAIR: begin
               if (!active_ff) begin
                  status_in = ows_pkg::STATUS_IGNORED;
               end else if (op.fail) begin
                  last_disc_in = '0;
                  active_in    = 1'b0;
                  status_in    = ows_pkg::STATUS_FAIL;
               end else begin
                  // Choose the branch: follow the bus, or at a fork replay the previous pass,
                  // take 1 at its last fork, and 0 at a new fork beyond it.
                  if (!op.both_zero) begin
                     dir = op.id_bit;
                  end else if (pos_ff < last_disc_ff) begin
                     dir = rom_ff[idx];
                  end else begin
                     dir = (pos_ff == last_disc_ff);
                  end
                  if (op.both_zero && !dir) begin
                     pass_disc_in = pos_ff;
                  end
                  rom_in[idx] = dir;
                  pos_in      = pos_ff + 1'b1;
                  dir_in      = dir;
                  if (pos_ff >= PosW'(ROM_BITS)) begin
                     // Last bit: report the device and set up the next pass.
                     last_disc_in = pass_disc_in;
                     done_in      = (pass_disc_in == '0);
                     active_in    = 1'b0;
                     status_in    = ows_pkg::STATUS_FOUND;
                     code_in      = ows_pkg::ROM_CODE_W'(rom_in);
                     more_in      = (pass_disc_in != '0);
                  end else begin
                     status_in = ows_pkg::STATUS_BIT;
                  end
               end
            end
            default: begin
               status_in = ows_pkg::STATUS_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      dir_ff    <= dir_in;
      code_ff   <= code_in;
      more_ff   <= more_in;
      if (reset) begin
         rom_ff       <= '0;
         pos_ff       <= PosW'(1);
         last_disc_ff <= '0;
         pass_disc_ff <= '0;
         done_ff      <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rom_ff       <= rom_in;
         pos_ff       <= pos_in;
         last_disc_ff <= last_disc_in;
         pass_disc_ff <= pass_disc_in;
         done_ff      <= done_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_direction_bit = dir_ff;
   assign rsp_rom_code      = code_ff;
   assign rsp_more_devices  = more_ff;

endmodule

// ===== hdl/onewire_rom_search_engine.sv =====
// Throughput: one transaction per cycle while rsp_stall is low; the two-entry queue
// and the response register let the request side keep flowing while a response
// waits, until the queue is full.
// Every bit pair is resolved by the combinational back-end decision logic.
// Reset is synchronous and active high; it clears all search state (no pass active).
`timescale 1ns / 1ps

module onewire_rom_search_engine #(
   parameter int ROM_BITS = ows_pkg::ROM_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic                           req_presence_ok,
   input  logic                           req_id_bit,
   input  logic                           req_complement_bit,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic                           rsp_direction_bit,
   output logic [ows_pkg::ROM_CODE_W-1:0] rsp_rom_code,
   output logic                           rsp_more_devices
);

   logic            q_push;
   logic            q_pop;
   logic            q_empty;
   logic            q_full;
   ows_pkg::op_type q_push_op;
   ows_pkg::op_type q_head_op;

   // Classification of incoming transactions.
   ows_front u_front (
      .req_valid          (req_valid),
      .req_command        (req_command),
      .req_presence_ok    (req_presence_ok),
      .req_id_bit         (req_id_bit),
      .req_complement_bit (req_complement_bit),
      .queue_full         (q_full),
      .req_stall          (req_stall),
      .push               (q_push),
      .push_op            (q_push_op)
   );

   // Decoupling queue.
   ows_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .pop     (q_pop),
      .head_op (q_head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   // Search engine and response register.
   ows_back #(
      .ROM_BITS (ROM_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .op_valid          (!q_empty),
      .op                (q_head_op),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_direction_bit (rsp_direction_bit),
      .rsp_rom_code      (rsp_rom_code),
      .rsp_more_devices  (rsp_more_devices)
   );

`ifndef SYNTH
   // An accepted transaction leaves the queue non-empty at the next edge.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_empty)
      else $error("accepted transaction did not reach the queue");

   // The back end only consumes when the queue holds something.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end consumed from an empty queue");

   // Only a found device carries a ROM code.
   a_code_only_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ows_pkg::STATUS_FOUND)) |-> (rsp_rom_code == '0))
      else $error("ROM code present on a response that is not a found device");
`endif

endmodule
